>>> rtl/core/rhh_pkg.sv
// Shared types, codes and helper functions of the Robin Hood hash table.
`default_nettype none
package rhh_pkg;

    // Operation codes carried in the input tuser.
    localparam logic [1:0] KIND_SET    = 2'd0;
    localparam logic [1:0] KIND_GET    = 2'd1;
    localparam logic [1:0] KIND_DEL    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Result codes carried in the output tuser.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_DELETED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_BYTES = 2'd0;
    localparam logic [1:0] REG_MAX_FILL  = 2'd1;

    // FNV-1a 64 constants. The prime is 2^40 + 0x1b3.
    localparam logic [63:0] FNV_OFFSET   = 64'hcbf29ce484222325;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
    localparam int          FNV_PRIME_SH = 40;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_F_RD,
        S_F_CHK,
        S_I_RD,
        S_I_CHK,
        S_D_RD,
        S_D_CHK,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        H_IDLE,
        H_MIX,
        H_MOD,
        H_RED
    } t_hash_state;

    // Number of key bytes in use: zero acts as one, above eight as eight.
    function automatic logic [3:0] eff_bytes(input logic [3:0] kb);
        logic [3:0] n;
        n = kb;
        if (kb == 4'd0) n = 4'd1;
        else if (kb > 4'd8) n = 4'd8;
        return n;
    endfunction

    // Mask that keeps the low key bytes in use.
    function automatic logic [63:0] key_mask(input logic [3:0] kb);
        logic [63:0] m;
        logic [3:0]  n;
        n = eff_bytes(kb);
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/rhh_hash.sv
// FNV-1a 64 key hash, one byte a cycle; home bucket by low bits or reciprocal reduction.
`default_nettype none
module rhh_hash #(
    parameter int CAPACITY = 256,
    parameter int AW       = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [63:0]   i_key,
    input  wire logic [3:0]    i_nbytes,
    output logic               o_done,
    output logic [63:0]        o_hash,
    output logic [AW-1:0]      o_home
);
    import rhh_pkg::*;

    localparam bit POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(CAPACITY));
    localparam logic [31:0] CAP32 = 32'(CAPACITY);

    t_hash_state   r_state, n_state;
    logic [63:0]   r_h, n_h;
    logic [63:0]   r_key, n_key;
    logic [3:0]    r_left, n_left;
    logic [63:0]   r_sh, n_sh;
    logic [1:0]    r_chunk, n_chunk;
    logic [31:0]   r_num, n_num;
    logic [16:0]   r_q, n_q;
    logic [15:0]   r_rem, n_rem;
    logic          r_done, n_done;
    logic [63:0]   w_x;
    logic [31:0]   w_num;
    logic [63:0]   w_prod;
    logic [31:0]   w_r1, w_r2, w_r3;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_h     <= n_h;
        r_key   <= n_key;
        r_left  <= n_left;
        r_sh    <= n_sh;
        r_chunk <= n_chunk;
        r_num   <= n_num;
        r_q     <= n_q;
        r_rem   <= n_rem;
    end

    // One FNV step per cycle, then the remainder 16 hash bits at a time.
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_key   = r_key;
        n_left  = r_left;
        n_sh    = r_sh;
        n_chunk = r_chunk;
        n_num   = r_num;
        n_q     = r_q;
        n_rem   = r_rem;
        n_done  = 1'b0;
        w_x     = r_h ^ {56'd0, r_key[7:0]};
        w_num   = {r_rem, r_sh[63:48]};
        w_prod  = {32'd0, w_num} * {32'd0, RECIP};
        w_r1    = r_num - r_q * CAP32;
        w_r2    = (w_r1 >= CAP32) ? w_r1 - CAP32 : w_r1;
        w_r3    = (w_r2 >= CAP32) ? w_r2 - CAP32 : w_r2;
        unique case (r_state)
            H_IDLE: begin
                if (i_start) begin
                    n_h     = FNV_OFFSET;
                    n_key   = i_key;
                    n_left  = i_nbytes;
                    n_state = H_MIX;
                end
            end
            H_MIX: begin
                n_h    = (w_x << FNV_PRIME_SH) + w_x * FNV_PRIME_LO;
                n_key  = r_key >> 8;
                n_left = r_left - 4'd1;
                if (r_left == 4'd1) begin
                    if (POW2) begin
                        n_state = H_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_sh    = n_h;
                        n_chunk = 2'd0;
                        n_rem   = '0;
                        n_state = H_MOD;
                    end
                end
            end
            H_MOD: begin
                // Quotient estimate of (remainder * 2^16 + chunk) by the reciprocal.
                n_num   = w_num;
                n_q     = w_prod[48:32];
                n_sh    = r_sh << 16;
                n_state = H_RED;
            end
            H_RED: begin
                // The estimate is at most one low, so the corrections settle it.
                n_rem   = w_r3[15:0];
                n_chunk = r_chunk + 2'd1;
                if (r_chunk == 2'd3) begin
                    n_state = H_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = H_MOD;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    assign o_done = r_done;
    assign o_hash = r_h;
    assign o_home = POW2 ? r_h[AW-1:0] : r_rem[AW-1:0];

endmodule
`default_nettype wire

>>> rtl/core/rhh_table.sv
// Bucket store: one synchronous memory of occupied flag, distance, hash, key, value.
`default_nettype none
module rhh_table #(
    parameter int CAPACITY    = 256,
    parameter int AW          = 8,
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rd_en,
    input  wire logic [AW-1:0]          i_rd_addr,
    output logic                        o_rd_occ,
    output logic [AW-1:0]               o_rd_dist,
    output logic [63:0]                 o_rd_hash,
    output logic [63:0]                 o_rd_key,
    output logic [VALUE_WIDTH-1:0]      o_rd_val,
    input  wire logic                   i_wr_en,
    input  wire logic [AW-1:0]          i_wr_addr,
    input  wire logic                   i_wr_occ,
    input  wire logic [AW-1:0]          i_wr_dist,
    input  wire logic [63:0]            i_wr_hash,
    input  wire logic [63:0]            i_wr_key,
    input  wire logic [VALUE_WIDTH-1:0] i_wr_val
);
    localparam int EW = 1 + AW + 64 + 64 + VALUE_WIDTH;

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] r_rd;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) mem[i_wr_addr] <= {i_wr_occ, i_wr_dist, i_wr_hash, i_wr_key, i_wr_val};
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) r_rd <= mem[i_rd_addr];
    end

    assign {o_rd_occ, o_rd_dist, o_rd_hash, o_rd_key, o_rd_val} = r_rd;

endmodule
`default_nettype wire

>>> rtl/core/robin_hood_hash_table.sv
// Top level: Robin Hood hash table with set, get and backward-shift delete.
//
//  Channel  | Direction | Handshake                 | Word
//  s (in)   | input     | i_s_tvalid / o_s_tready   | tuser kind, tdata key and value
//  m (out)  | output    | o_m_tvalid / i_m_tready   | tuser status, tdata value and count
//  cfg      | input     | i_cfg_valid / o_cfg_ready | register index and data
//
// An item takes the hash (one key byte per cycle, plus a remainder step on four
// 16-bit chunks when CAPACITY is not a power of two) and then a visit per bucket,
// each a memory read followed by a check that may write back.
// After reset a clearing pass over all CAPACITY buckets empties the store; no word is
// accepted meanwhile. One item is in work at a time; a finished result waits
// in the output register while the next word is taken.
`default_nettype none
module robin_hood_hash_table #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [127:0] i_s_tdata,   // key [63:0], value [127:64]
    input  wire logic [1:0]   i_s_tuser,   // kind [1:0]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [79:0]       o_m_tdata,   // value_out [63:0], live_count [72:64], zero
    output logic [2:0]        o_m_tuser,   // status [2:0]
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [8:0]   i_cfg_data
);
    import rhh_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    t_state                 r_state, n_state;
    logic [3:0]             r_key_bytes;
    logic [8:0]             r_max_fill;
    logic [1:0]             r_kind, n_kind;
    logic [63:0]            r_key, n_key;
    logic [63:0]            r_hash, n_hash;
    logic [AW-1:0]          r_slot, n_slot;
    logic [AW-1:0]          r_hole, n_hole;
    logic [AW:0]            r_dist, n_dist;
    logic [63:0]            r_c_key, n_c_key;
    logic [63:0]            r_c_hash, n_c_hash;
    logic [VALUE_WIDTH-1:0] r_c_val, n_c_val;
    logic [CW-1:0]          r_count, n_count;
    logic [2:0]             r_res_st, n_res_st;
    logic [63:0]            r_res_val, n_res_val;
    logic                   r_out_valid;
    logic [2:0]             r_out_st;
    logic [63:0]            r_out_val;
    logic [8:0]             r_out_cnt;

    logic                   w_hash_start;
    logic                   w_hash_done;
    logic [63:0]            w_hash;
    logic [AW-1:0]          w_home;
    logic                   w_rd_en;
    logic                   w_rd_occ;
    logic [AW-1:0]          w_rd_dist;
    logic [63:0]            w_rd_hash;
    logic [63:0]            w_rd_key;
    logic [VALUE_WIDTH-1:0] w_rd_val;
    logic                   w_wr_en;
    logic [AW-1:0]          w_wr_addr;
    logic                   w_wr_occ;
    logic [AW-1:0]          w_wr_dist;
    logic [63:0]            w_wr_hash;
    logic [63:0]            w_wr_key;
    logic [VALUE_WIDTH-1:0] w_wr_val;
    logic                   w_accept;
    logic                   w_match;
    logic                   w_full;
    logic [AW-1:0]          w_next;
    logic [63:0]            w_mask;

    rhh_hash #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_hash_start),
        .i_key    (i_s_tdata[63:0] & w_mask),
        .i_nbytes (eff_bytes(r_key_bytes)),
        .o_done   (w_hash_done),
        .o_hash   (w_hash),
        .o_home   (w_home)
    );

    rhh_table #(
        .CAPACITY    (CAPACITY),
        .AW          (AW),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_slot),
        .o_rd_occ  (w_rd_occ),
        .o_rd_dist (w_rd_dist),
        .o_rd_hash (w_rd_hash),
        .o_rd_key  (w_rd_key),
        .o_rd_val  (w_rd_val),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_occ  (w_wr_occ),
        .i_wr_dist (w_wr_dist),
        .i_wr_hash (w_wr_hash),
        .i_wr_key  (w_wr_key),
        .i_wr_val  (w_wr_val)
    );

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bytes <= 4'd8;
            r_max_fill  <= 9'd192;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_KEY_BYTES) r_key_bytes <= i_cfg_data[3:0];
            else if (i_cfg_index == REG_MAX_FILL) r_max_fill <= i_cfg_data;
        end
    end

    assign w_mask       = key_mask(r_key_bytes);
    assign o_s_tready   = (r_state == S_IDLE);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_hash_start = w_accept && (i_s_tuser != KIND_UNUSED);
    assign w_next       = (r_slot == LAST) ? '0 : r_slot + AW'(1);
    assign w_match      = (w_rd_hash == r_hash) && (((w_rd_key ^ r_key) & w_mask) == 64'd0);
    assign w_full       = (32'(r_count) >= 32'(r_max_fill)) || (32'(r_count) >= CAPACITY);

    // Control state and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_slot  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_count <= n_count;
        end
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_hash    <= n_hash;
        r_hole    <= n_hole;
        r_dist    <= n_dist;
        r_c_key   <= n_c_key;
        r_c_hash  <= n_c_hash;
        r_c_val   <= n_c_val;
        r_res_st  <= n_res_st;
        r_res_val <= n_res_val;
    end

    // Sequencer: clearing pass, hash wait, probe, insert and backward shift.
    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_count   = r_count;
        n_kind    = r_kind;
        n_key     = r_key;
        n_hash    = r_hash;
        n_hole    = r_hole;
        n_dist    = r_dist;
        n_c_key   = r_c_key;
        n_c_hash  = r_c_hash;
        n_c_val   = r_c_val;
        n_res_st  = r_res_st;
        n_res_val = r_res_val;
        w_rd_en   = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_slot;
        w_wr_occ  = 1'b0;
        w_wr_dist = w_rd_dist;
        w_wr_hash = w_rd_hash;
        w_wr_key  = w_rd_key;
        w_wr_val  = w_rd_val;
        unique case (r_state)
            S_CLEAR: begin
                w_wr_en = 1'b1;
                n_slot  = w_next;
                if (r_slot == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_kind    = i_s_tuser;
                    n_key     = i_s_tdata[63:0] & w_mask;
                    n_c_val   = i_s_tdata[64 +: VALUE_WIDTH];
                    n_res_val = 64'd0;
                    if (i_s_tuser == KIND_UNUSED) begin
                        n_res_st = ST_NOT_FOUND;
                        n_state  = S_RESP;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (w_hash_done) begin
                    n_hash  = w_hash;
                    n_slot  = w_home;
                    n_dist  = '0;
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                w_rd_en = 1'b1;
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (!w_rd_occ || ((AW+1)'(w_rd_dist) < r_dist) || (!w_match &&
                        (r_dist == (AW+1)'(CAPACITY - 1)))) begin
                    // Key absent.
                    n_res_st = ST_NOT_FOUND;
                    n_state  = S_RESP;
                    if (r_kind == KIND_SET) begin
                        if (w_full) begin
                            n_res_st = ST_FULL;
                        end else begin
                            n_slot   = w_home;
                            n_dist   = '0;
                            n_c_key  = r_key;
                            n_c_hash = r_hash;
                            n_state  = S_I_RD;
                        end
                    end
                end else if (w_match) begin
                    n_state = S_RESP;
                    unique case (r_kind)
                        KIND_SET: begin
                            w_wr_en  = 1'b1;
                            w_wr_occ = 1'b1;
                            w_wr_val = r_c_val;
                            n_res_st = ST_UPDATED;
                        end
                        KIND_GET: begin
                            n_res_st  = ST_FOUND;
                            n_res_val = 64'(w_rd_val);
                        end
                        default: begin
                            n_hole  = r_slot;
                            n_slot  = w_next;
                            n_dist  = '0;
                            n_state = S_D_RD;
                        end
                    endcase
                end else begin
                    n_dist = r_dist + (AW+1)'(1);
                    n_slot = w_next;
                    n_state = S_F_RD;
                end
            end
            S_I_RD: begin
                w_rd_en = 1'b1;
                n_state = S_I_CHK;
            end
            S_I_CHK: begin
                w_wr_occ  = 1'b1;
                w_wr_dist = r_dist[AW-1:0];
                w_wr_hash = r_c_hash;
                w_wr_key  = r_c_key;
                w_wr_val  = r_c_val;
                if (!w_rd_occ) begin
                    w_wr_en  = 1'b1;
                    n_count  = r_count + CW'(1);
                    n_res_st = ST_INSERTED;
                    n_state  = S_RESP;
                end else if ((AW+1)'(w_rd_dist) < r_dist) begin
                    // Resident is richer: swap and carry it on.
                    w_wr_en  = 1'b1;
                    n_c_hash = w_rd_hash;
                    n_c_key  = w_rd_key;
                    n_c_val  = w_rd_val;
                    n_dist   = (AW+1)'(w_rd_dist) + (AW+1)'(1);
                    n_slot   = w_next;
                    n_state  = S_I_RD;
                end else begin
                    n_dist  = r_dist + (AW+1)'(1);
                    n_slot  = w_next;
                    n_state = S_I_RD;
                end
            end
            S_D_RD: begin
                w_rd_en = 1'b1;
                n_state = S_D_CHK;
            end
            S_D_CHK: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_hole;
                if (!w_rd_occ || (w_rd_dist == '0) ||
                        (r_dist == (AW+1)'(CAPACITY - 1))) begin
                    w_wr_occ = 1'b0;
                    n_count  = r_count - CW'(1);
                    n_res_st = ST_DELETED;
                    n_state  = S_RESP;
                end else begin
                    // Pull the next displaced entry back into the hole.
                    w_wr_occ  = 1'b1;
                    w_wr_dist = w_rd_dist - AW'(1);
                    n_hole    = r_slot;
                    n_slot    = w_next;
                    n_dist    = r_dist + (AW+1)'(1);
                    n_state   = S_D_RD;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_m_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_RESP && (!r_out_valid || i_m_tready)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == S_RESP && (!r_out_valid || i_m_tready)) begin
            r_out_st  <= r_res_st;
            r_out_val <= r_res_val;
            r_out_cnt <= 9'(r_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_st;
    assign o_m_tdata  = {7'd0, r_out_cnt, r_out_val};

endmodule
`default_nettype wire
